>>> design/remote_frame_pwm_transmitter_unit_macros.svh
// Assertion macros for the remote frame PWM transmitter checker.
// No dependencies; included by the checker file.
`ifndef REMOTE_FRAME_PWM_TRANSMITTER_UNIT_MACROS_SVH
`define REMOTE_FRAME_PWM_TRANSMITTER_UNIT_MACROS_SVH

// Clocked check, quiet while reset is high.
`define RFPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define RFPT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/rfpt_pkg.sv
// Shared constants for the remote frame PWM transmitter.
// No dependencies; used by the top level and its checker.
package rfpt_pkg;

  // configuration port
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int REPEAT_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_US    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_US     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_US     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_CNT  = 2'd3;

  localparam logic [CFG_W-1:0]    SHORT_US_RST     = 13'd290;
  localparam logic [CFG_W-1:0]    LONG_US_RST      = 13'd860;
  localparam logic [CFG_W-1:0]    SYNC_US_RST      = 13'd4375;
  localparam logic [REPEAT_W-1:0] REPEAT_CNT_RST   = 4'd5;

  // frame sections
  localparam int SEC_W = 3;
  localparam logic [SEC_W-1:0] SEC_IDLE       = 3'd0;
  localparam logic [SEC_W-1:0] SEC_PRE_CMD    = 3'd1;
  localparam logic [SEC_W-1:0] SEC_PRE_ID     = 3'd2;
  localparam logic [SEC_W-1:0] SEC_FIRST_SYNC = 3'd3;
  localparam logic [SEC_W-1:0] SEC_BLK_CMD    = 3'd4;
  localparam logic [SEC_W-1:0] SEC_BLK_ID     = 3'd5;
  localparam logic [SEC_W-1:0] SEC_BLK_SYNC   = 3'd6;

  // result word: line_level, busy_res, done_res from bit 0 up
  localparam int RES_W      = 3;
  localparam int OUT_TDATA_W = 8;
  localparam int RES_LINE   = 0;
  localparam int RES_BUSY   = 1;
  localparam int RES_DONE   = 2;

  typedef logic [RES_W-1:0] result_t;

endpackage

>>> design/remote_frame_pwm_transmitter_unit.sv
// Remote frame PWM transmitter: on-off-keyed pulse-width remote code encoder.
// Depends on rfpt_pkg.
// Use:
//   Every request on the s_ side is either one microsecond tick (s_tuser = 0)
//   or a frame start (s_tuser = 1, s_tdata carries command and remote ID).
//   A start latches both words and sends the frame on the line level: command
//   without its first bit, full ID, sync, then repeat_count blocks of full
//   command, ID without its last bit, and a sync.  Drop a start that arrives
//   while a frame runs; it does not count as a tick.
//   Every request yields one result on the m_ side: line level, busy flag and
//   a done flag that is high on the tick the last half ends.
// Throughput:
//   One request per clock while s_tready is high.  The state update is one pass of short
//   logic; the result is registered at the edge that takes the request, in the output
//   register, or in the skid register while the output stalls.
// Stalls:
//   Output register plus skid register keep s_tready high while one result
//   waits on m_tready; s_tready drops only when both are full.
// Reset (rst, synchronous, active high):
//   Idle frame state, line low, empty output stage, timing registers at
//   290 / 860 / 4375 ticks and 5 repeats.  Take cfg_we writes at any edge.
module remote_frame_pwm_transmitter_unit #(
  parameter int CMD_BITS  = 16,
  parameter int ID_BITS   = 17,
  parameter int TIME_BITS = 13,
  localparam int S_TDATA_W = ((CMD_BITS + ID_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [rfpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rfpt_pkg::CFG_W-1:0]     cfg_data,
  // request stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [S_TDATA_W-1:0]           s_tdata,  // command_code, remote_id, zero pad
  input  logic                           s_tuser,  // func: 0 tick, 1 start
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rfpt_pkg::OUT_TDATA_W-1:0] m_tdata // line_level, busy_res, done_res, pad
);
  import rfpt_pkg::*;

  localparam int MAX_BITS = (CMD_BITS > ID_BITS) ? CMD_BITS : ID_BITS;
  localparam int IDX_W    = $clog2(MAX_BITS);

  // Turn a register value into a half duration; zero counts as one tick.
  function automatic logic [TIME_BITS-1:0] half_ticks(input logic [CFG_W-1:0] v);
    logic [TIME_BITS-1:0] t;
    t = TIME_BITS'(v);
    return (t == '0) ? TIME_BITS'(1) : t;
  endfunction

  // configuration registers
  logic [CFG_W-1:0]    short_us, long_us, sync_us;
  logic [REPEAT_W-1:0] repeat_count;

  // frame state
  logic [CMD_BITS-1:0]  latched_command, latched_command_next;
  logic [ID_BITS-1:0]   latched_identity, latched_identity_next;
  logic [SEC_W-1:0]     frame_section, frame_section_next;
  logic [IDX_W-1:0]     symbol_index, symbol_index_next;
  logic                 half_phase, half_phase_next;
  logic [TIME_BITS-1:0] time_left, time_left_next;
  logic [REPEAT_W-1:0]  blocks_sent, blocks_sent_next;
  logic                 pin_level, pin_level_next;
  logic                 done_next;

  // output stage
  logic    out_valid, skid_valid;
  result_t out_data, skid_data;
  result_t step_res;
  logic    accept;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'(out_data);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      short_us     <= SHORT_US_RST;
      long_us      <= LONG_US_RST;
      sync_us      <= SYNC_US_RST;
      repeat_count <= REPEAT_CNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHORT_US:   short_us     <= cfg_data;
        REG_LONG_US:    long_us      <= cfg_data;
        REG_SYNC_US:    sync_us      <= cfg_data;
        REG_REPEAT_CNT: repeat_count <= cfg_data[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Single pass: next frame state for one request.
  always_comb begin
    logic                 do_load;
    logic [SEC_W-1:0]     ld_sec;
    logic [IDX_W-1:0]     ld_idx;
    logic                 ld_phase;
    logic [CMD_BITS-1:0]  cmd_sh;
    logic [ID_BITS-1:0]   id_sh;
    logic                 sym_bit;
    logic                 sym_sync;
    logic [CFG_W-1:0]     dur_sel;
    logic [TIME_BITS-1:0] tl_dec;
    logic [REPEAT_W-1:0]  blk_inc;
    logic                 more;

    latched_command_next  = latched_command;
    latched_identity_next = latched_identity;
    frame_section_next    = frame_section;
    symbol_index_next     = symbol_index;
    half_phase_next       = half_phase;
    time_left_next        = time_left;
    blocks_sent_next      = blocks_sent;
    pin_level_next        = pin_level;
    done_next             = 1'b0;
    do_load               = 1'b0;
    more                  = 1'b1;
    tl_dec                = (time_left != '0) ? time_left - TIME_BITS'(1) : '0;
    blk_inc               = blocks_sent + REPEAT_W'(1);

    if (frame_section == SEC_IDLE) begin
      // start: latch words, first symbol is the command's second bit
      if (s_tuser) begin
        latched_command_next  = s_tdata[CMD_BITS-1:0];
        latched_identity_next = s_tdata[CMD_BITS +: ID_BITS];
        frame_section_next    = SEC_PRE_CMD;
        symbol_index_next     = IDX_W'(CMD_BITS - 2);
        blocks_sent_next      = '0;
        half_phase_next       = 1'b0;
        do_load               = 1'b1;
      end
    end else if (!s_tuser) begin
      time_left_next = tl_dec;
      if (tl_dec == '0) begin
        if (!half_phase) begin
          half_phase_next = 1'b1;
          do_load         = 1'b1;
        end else begin
          // advance to the next symbol
          case (frame_section)
            SEC_PRE_CMD, SEC_BLK_CMD: begin
              if (symbol_index != '0) begin
                symbol_index_next = symbol_index - IDX_W'(1);
              end else begin
                frame_section_next = (frame_section == SEC_PRE_CMD) ? SEC_PRE_ID : SEC_BLK_ID;
                symbol_index_next  = IDX_W'(ID_BITS - 1);
              end
            end
            SEC_PRE_ID: begin
              if (symbol_index != '0) begin
                symbol_index_next = symbol_index - IDX_W'(1);
              end else begin
                frame_section_next = SEC_FIRST_SYNC;
              end
            end
            SEC_BLK_ID: begin
              if (symbol_index > IDX_W'(1)) begin
                symbol_index_next = symbol_index - IDX_W'(1);
              end else begin
                frame_section_next = SEC_BLK_SYNC;
              end
            end
            SEC_FIRST_SYNC: begin
              blocks_sent_next = '0;
              if (repeat_count == '0) begin
                more = 1'b0;
              end else begin
                frame_section_next = SEC_BLK_CMD;
                symbol_index_next  = IDX_W'(CMD_BITS - 1);
              end
            end
            SEC_BLK_SYNC: begin
              blocks_sent_next = blk_inc;
              if (blk_inc >= repeat_count || blk_inc == '0) begin
                more = 1'b0;
              end else begin
                frame_section_next = SEC_BLK_CMD;
                symbol_index_next  = IDX_W'(CMD_BITS - 1);
              end
            end
            default: more = 1'b0;
          endcase

          if (more) begin
            half_phase_next = 1'b0;
            do_load         = 1'b1;
          end else begin
            // frame over: line low, drop busy, flag done
            frame_section_next = SEC_IDLE;
            symbol_index_next  = '0;
            half_phase_next    = 1'b0;
            time_left_next     = '0;
            pin_level_next     = 1'b0;
            done_next          = 1'b1;
          end
        end
      end
    end

    // load the duration and level of the half that begins now
    ld_sec   = frame_section_next;
    ld_idx   = symbol_index_next;
    ld_phase = half_phase_next;
    cmd_sh   = latched_command_next >> ld_idx;
    id_sh    = latched_identity_next >> ld_idx;
    sym_sync = 1'b0;
    case (ld_sec)
      SEC_PRE_CMD, SEC_BLK_CMD: sym_bit = cmd_sh[0];
      SEC_PRE_ID, SEC_BLK_ID:   sym_bit = id_sh[0];
      default: begin
        sym_bit  = 1'b0;
        sym_sync = 1'b1;
      end
    endcase
    if (!ld_phase) begin
      dur_sel = (!sym_sync && !sym_bit) ? long_us : short_us;
    end else if (sym_sync) begin
      dur_sel = sync_us;
    end else begin
      dur_sel = sym_bit ? long_us : short_us;
    end
    if (do_load) begin
      time_left_next = half_ticks(dur_sel);
      pin_level_next = !ld_phase;
    end
  end

  always_comb begin
    step_res           = '0;
    step_res[RES_LINE] = pin_level_next;
    step_res[RES_BUSY] = (frame_section_next != SEC_IDLE);
    step_res[RES_DONE] = done_next;
  end

  // commit the state on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_section <= SEC_IDLE;
      symbol_index  <= '0;
      half_phase    <= 1'b0;
      time_left     <= '0;
      blocks_sent   <= '0;
      pin_level     <= 1'b0;
      latched_command  <= '0;
      latched_identity <= '0;
    end else if (accept) begin
      frame_section    <= frame_section_next;
      symbol_index     <= symbol_index_next;
      half_phase       <= half_phase_next;
      time_left        <= time_left_next;
      blocks_sent      <= blocks_sent_next;
      pin_level        <= pin_level_next;
      latched_command  <= latched_command_next;
      latched_identity <= latched_identity_next;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_data <= skid_valid ? skid_data : step_res;
    end else if (accept) begin
      skid_data <= step_res;
    end
  end

endmodule

>>> design/rfpt_checker.sv
// Port-level checks for remote_frame_pwm_transmitter_unit, with its bind.
// Depends on rfpt_pkg and remote_frame_pwm_transmitter_unit_macros.svh.
`include "remote_frame_pwm_transmitter_unit_macros.svh"

module rfpt_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [rfpt_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import rfpt_pkg::*;

  logic line_bit, busy_bit, done_bit;

  assign line_bit = m_tdata[RES_LINE];
  assign busy_bit = m_tdata[RES_BUSY];
  assign done_bit = m_tdata[RES_DONE];

  // a stalled result holds
  `RFPT_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `RFPT_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed")
  // done leaves the line low and busy clear
  `RFPT_ASSERT(a_done_idle, m_tvalid && done_bit |-> !busy_bit && !line_bit, "done while busy")
  // the line is only high inside a frame
  `RFPT_ASSERT(a_line_busy, m_tvalid && line_bit |-> busy_bit, "line high while idle")
  // reset empties the output stage
  `RFPT_ASSERT_RST(a_rst_empty, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind remote_frame_pwm_transmitter_unit rfpt_checker u_rfpt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
